// ===== src/cdfs_pkg.sv =====
`default_nettype none

package cdfs_pkg;

   // Hash register constants
   localparam logic [63:0] SEED_CONST      = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL_A       = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B       = 64'h94D0_49BB_1331_11EB;
   // FNV prime is 2^40 + 0x1B3
   localparam int unsigned FNV_PRIME_SHIFT = 40;
   localparam logic [63:0] FNV_PRIME_LOW   = 64'h0000_0000_0000_01B3;

   // Input command codes
   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_ABSORB   = 2'd1;
   localparam logic [1:0] CMD_FINALIZE = 2'd2;
   localparam logic [1:0] CMD_GENERATE = 2'd3;

   // Result kinds
   localparam logic KIND_DIGEST = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   localparam logic [1:0] LAST_WORD = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_FOLD,
      ST_GEN,
      ST_GEN_EMIT,
      ST_XS30,
      ST_MA_LL,
      ST_MA_HL,
      ST_MA_LH,
      ST_XS27,
      ST_MB_LL,
      ST_MB_HL,
      ST_MB_LH,
      ST_XS31,
      ST_WORD_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_SEED,
      OP_FOLD,
      OP_XS30,
      OP_XS27,
      OP_XS31,
      OP_MUL_LL,
      OP_MUL_HL,
      OP_MUL_LH
   } dp_op_type;

   typedef struct packed {
      logic       capture;
      dp_op_type  op;
      logic       mul_sel_b;
      logic       load_out;
      logic       out_kind;
      logic       out_last;
      logic [1:0] out_index;
   } dp_cmd_type;

   // x * (2^40 + 0x1B3) modulo 2^64: a shift and a narrow constant product
   function automatic logic [63:0] fnv_mul(input logic [63:0] x);
      logic [63:0] shifted;
      logic [63:0] low_part;
      shifted  = x << FNV_PRIME_SHIFT;
      low_part = x * FNV_PRIME_LOW;
      return shifted + low_part;
   endfunction

endpackage

`default_nettype wire

// ===== src/compute_digest_and_fill_stream.sv =====
`default_nettype none

// Digest and filler-stream engine. One 64-bit hash register (reset to the
// golden-ratio seed) takes commands one at a time: start seeds it from the
// opcode, absorb folds in a byte FNV-1a style, finalize runs four splitmix64
// rounds and returns four 32-bit digest words (upper OR lower half of the
// register after each round, word_index 0..3, last on word 3), and generate
// folds in a byte position and returns the register's top byte as filler
// (kind 1, last set). Start and absorb end after their seed or fold step;
// generate folds and then emits. A finalize round runs xorshift, multiply,
// xorshift, multiply, xorshift and emit; the single shared 32x32 multiplier
// needs three passes for each of the two 64-bit constant products in it.
// req_stall is high while a command is in progress; results sit in an
// output register, so a new item is taken while the last result still waits.
// Commands are not checked for sequence: each one acts on the current hash.

module compute_digest_and_fill_stream (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_opcode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [31:0] req_position,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [31:0]      rsp_value,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_last
);

   // controller drives the datapath one operation per cycle, pausing while a result waits in the output register
   cdfs_pkg::dp_cmd_type dp_cmd;

   cdfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // hash register, multiply accumulator, operand capture and result payload
   cdfs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .req_cmd        (req_cmd),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_position   (req_position),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_word_index (rsp_word_index),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== src/cdfs_datapath.sv =====
`default_nettype none

module cdfs_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cdfs_pkg::dp_cmd_type dp_cmd,
   input  wire logic [1:0]          req_cmd,
   input  wire logic [31:0]         req_opcode,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic [31:0]         req_position,
   output logic                     rsp_kind,
   output logic [31:0]              rsp_value,
   output logic [1:0]               rsp_word_index,
   output logic                     rsp_last
);

   logic [63:0] hash_ff, hash_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] operand_ff, operand_in;
   logic        kind_ff, last_ff;
   logic [31:0] value_ff, value_in;
   logic [1:0]  index_ff;

   logic [63:0] mul_const;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [31:0] cross_sum;

   // Shared 32x32 multiplier: three passes build one 64-bit product
   always_comb begin
      mul_const = dp_cmd.mul_sel_b ? cdfs_pkg::MIX_MUL_B : cdfs_pkg::MIX_MUL_A;
      mul_a     = (dp_cmd.op == cdfs_pkg::OP_MUL_HL) ? hash_ff[63:32] : hash_ff[31:0];
      mul_b     = (dp_cmd.op == cdfs_pkg::OP_MUL_LH) ? mul_const[63:32] : mul_const[31:0];
      prod      = {32'd0, mul_a} * {32'd0, mul_b};
      cross_sum = acc_ff[63:32] + prod[31:0];
   end

   always_comb begin
      operand_in = operand_ff;
      if (dp_cmd.capture) begin
         case (req_cmd)
            cdfs_pkg::CMD_START:    operand_in = req_opcode;
            cdfs_pkg::CMD_ABSORB:   operand_in = {24'd0, req_data_byte};
            cdfs_pkg::CMD_GENERATE: operand_in = req_position;
            default:                operand_in = operand_ff;
         endcase
      end
   end

   always_comb begin
      hash_in = hash_ff;
      acc_in  = acc_ff;
      case (dp_cmd.op)
         cdfs_pkg::OP_SEED:
            hash_in = cdfs_pkg::SEED_CONST ^ cdfs_pkg::fnv_mul({32'd0, operand_ff});
         cdfs_pkg::OP_FOLD:
            hash_in = cdfs_pkg::fnv_mul(hash_ff ^ {32'd0, operand_ff});
         cdfs_pkg::OP_XS30:   hash_in = hash_ff ^ (hash_ff >> 30);
         cdfs_pkg::OP_XS27:   hash_in = hash_ff ^ (hash_ff >> 27);
         cdfs_pkg::OP_XS31:   hash_in = hash_ff ^ (hash_ff >> 31);
         cdfs_pkg::OP_MUL_LL: acc_in  = prod;
         cdfs_pkg::OP_MUL_HL: acc_in  = {cross_sum, acc_ff[31:0]};
         cdfs_pkg::OP_MUL_LH: hash_in = {cross_sum, acc_ff[31:0]};
         default: begin
            hash_in = hash_ff;
            acc_in  = acc_ff;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.out_kind == cdfs_pkg::KIND_BYTE) begin
         value_in = {24'd0, hash_ff[63:56]};
      end else begin
         value_in = hash_ff[63:32] | hash_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= cdfs_pkg::SEED_CONST;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      operand_ff <= operand_in;
      if (dp_cmd.load_out) begin
         kind_ff  <= dp_cmd.out_kind;
         value_ff <= value_in;
         index_ff <= dp_cmd.out_index;
         last_ff  <= dp_cmd.out_last;
      end
   end

   assign rsp_kind       = kind_ff;
   assign rsp_value      = value_ff;
   assign rsp_word_index = index_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== src/cdfs_ctrl.sv =====
`default_nettype none

module cdfs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_cmd,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output cdfs_pkg::dp_cmd_type      dp_cmd
);

   cdfs_pkg::state_type state_ff, state_in;
   logic [1:0] round_ff, round_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != cdfs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdfs_pkg::ST_IDLE;
         round_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      round_in         = round_ff;
      dp_cmd           = '0;
      dp_cmd.op        = cdfs_pkg::OP_NONE;
      dp_cmd.out_kind  = cdfs_pkg::KIND_DIGEST;
      case (state_ff)
         cdfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               round_in       = 2'd0;
               case (req_cmd)
                  cdfs_pkg::CMD_START:    state_in = cdfs_pkg::ST_SEED;
                  cdfs_pkg::CMD_ABSORB:   state_in = cdfs_pkg::ST_FOLD;
                  cdfs_pkg::CMD_FINALIZE: state_in = cdfs_pkg::ST_XS30;
                  cdfs_pkg::CMD_GENERATE: state_in = cdfs_pkg::ST_GEN;
                  default:                state_in = cdfs_pkg::ST_IDLE;
               endcase
            end
         end
         cdfs_pkg::ST_SEED: begin
            dp_cmd.op = cdfs_pkg::OP_SEED;
            state_in  = cdfs_pkg::ST_IDLE;
         end
         cdfs_pkg::ST_FOLD: begin
            dp_cmd.op = cdfs_pkg::OP_FOLD;
            state_in  = cdfs_pkg::ST_IDLE;
         end
         cdfs_pkg::ST_GEN: begin
            dp_cmd.op = cdfs_pkg::OP_FOLD;
            state_in  = cdfs_pkg::ST_GEN_EMIT;
         end
         cdfs_pkg::ST_GEN_EMIT: begin
            // hold until the output register frees up
            dp_cmd.out_kind = cdfs_pkg::KIND_BYTE;
            dp_cmd.out_last = 1'b1;
            if (slot_free) begin
               dp_cmd.load_out = 1'b1;
               state_in        = cdfs_pkg::ST_IDLE;
            end
         end
         cdfs_pkg::ST_XS30: begin
            dp_cmd.op = cdfs_pkg::OP_XS30;
            state_in  = cdfs_pkg::ST_MA_LL;
         end
         cdfs_pkg::ST_MA_LL: begin
            dp_cmd.op = cdfs_pkg::OP_MUL_LL;
            state_in  = cdfs_pkg::ST_MA_HL;
         end
         cdfs_pkg::ST_MA_HL: begin
            dp_cmd.op = cdfs_pkg::OP_MUL_HL;
            state_in  = cdfs_pkg::ST_MA_LH;
         end
         cdfs_pkg::ST_MA_LH: begin
            dp_cmd.op = cdfs_pkg::OP_MUL_LH;
            state_in  = cdfs_pkg::ST_XS27;
         end
         cdfs_pkg::ST_XS27: begin
            dp_cmd.op = cdfs_pkg::OP_XS27;
            state_in  = cdfs_pkg::ST_MB_LL;
         end
         cdfs_pkg::ST_MB_LL: begin
            dp_cmd.op        = cdfs_pkg::OP_MUL_LL;
            dp_cmd.mul_sel_b = 1'b1;
            state_in         = cdfs_pkg::ST_MB_HL;
         end
         cdfs_pkg::ST_MB_HL: begin
            dp_cmd.op        = cdfs_pkg::OP_MUL_HL;
            dp_cmd.mul_sel_b = 1'b1;
            state_in         = cdfs_pkg::ST_MB_LH;
         end
         cdfs_pkg::ST_MB_LH: begin
            dp_cmd.op        = cdfs_pkg::OP_MUL_LH;
            dp_cmd.mul_sel_b = 1'b1;
            state_in         = cdfs_pkg::ST_XS31;
         end
         cdfs_pkg::ST_XS31: begin
            dp_cmd.op = cdfs_pkg::OP_XS31;
            state_in  = cdfs_pkg::ST_WORD_EMIT;
         end
         cdfs_pkg::ST_WORD_EMIT: begin
            dp_cmd.out_index = round_ff;
            dp_cmd.out_last  = (round_ff == cdfs_pkg::LAST_WORD);
            if (slot_free) begin
               dp_cmd.load_out = 1'b1;
               round_in        = round_ff + 2'd1;
               state_in        = (round_ff == cdfs_pkg::LAST_WORD) ? cdfs_pkg::ST_IDLE
                                                                   : cdfs_pkg::ST_XS30;
            end
         end
         default: begin
            state_in = cdfs_pkg::ST_IDLE;
         end
      endcase

      if (dp_cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

endmodule

`default_nettype wire

// ===== src/cdfs_checker.sv =====
`default_nettype none

module cdfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [31:0] rsp_value,
   input wire logic [1:0]  rsp_word_index,
   input wire logic        rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_kind)
         && $stable(rsp_word_index) && $stable(rsp_last))
      else $error("stalled result changed");

   // one command at a time: stall right after each transfer in
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   a_byte_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last && rsp_word_index == 2'd0
         && rsp_value[31:8] == 24'd0)
      else $error("malformed filler byte");

   a_digest_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_last == (rsp_word_index == 2'd3))
      else $error("digest last flag mismatch");

   // a digest word taken before the last must not be followed directly by a filler byte
   a_digest_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_kind && !rsp_last
         |=> !rsp_valid || rsp_kind == 1'b0)
      else $error("digest sequence broken");

endmodule

bind compute_digest_and_fill_stream cdfs_checker u_cdfs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_value      (rsp_value),
   .rsp_word_index (rsp_word_index),
   .rsp_last       (rsp_last)
);

`default_nettype wire
